@@ sv/esb_receiver_ack_controller_top_macros.svh @@
// Assertion macros for the receiver ack controller checker.
`ifndef ESB_RECEIVER_ACK_CONTROLLER_TOP_MACROS_SVH
`define ESB_RECEIVER_ACK_CONTROLLER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESBRAC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESBRAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/esbrac_pkg.sv @@
// Package with the request and result types and codes of the receiver ack controller.
package esbrac_pkg;

    localparam int RX_DEPTH_DEF = 4;
    localparam int TX_DEPTH_DEF = 4;

    localparam logic [1:0] KIND_RADIO_END = 2'd0;
    localparam logic [1:0] KIND_RX_RELEASE = 2'd1;
    localparam logic [1:0] KIND_TX_COMMIT = 2'd2;

    localparam logic [1:0] ACTION_NONE = 2'd0;
    localparam logic [1:0] ACTION_RX_RESTART = 2'd1;
    localparam logic [1:0] ACTION_ACK_TX = 2'd2;
    localparam logic [1:0] ACTION_RX_START = 2'd3;

    localparam logic [1:0] BUF_RX_SLOT = 2'd0;
    localparam logic [1:0] BUF_TX_SLOT = 2'd1;
    localparam logic [1:0] BUF_EMPTY_ACK = 2'd2;

    typedef enum logic [1:0] {
        PHASE_RX  = 2'b01,
        PHASE_ACK = 2'b10
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        crc_ok;
        logic [1:0]  packet_id;
        logic [15:0] packet_crc;
    } req_t;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] buffer_kind;
        logic [1:0] buffer_slot;
        logic       meta_write;
        logic [1:0] meta_slot;
        logic       rx_ready;
        logic [1:0] rx_read_slot;
        logic       tx_space;
        logic [1:0] tx_write_slot;
    } res_t;

endpackage

@@ sv/esbrac_stage.sv @@
// Valid/ready pipeline register stage for one request or result.
module esbrac_stage #(
    parameter type data_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    output logic  up_ready,
    input  data_t up_data,
    output logic  dn_valid,
    input  logic  dn_ready,
    output data_t dn_data
);

    logic  valid_reg;
    data_t data_reg;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= up_data;
        end
    end

endmodule

@@ sv/esbrac_ctrl.sv @@
// Ring indices, radio phase and ack bookkeeping with the result logic for one request.
module esbrac_ctrl #(
    parameter int RX_DEPTH = esbrac_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = esbrac_pkg::TX_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  esbrac_pkg::req_t  req,
    output esbrac_pkg::res_t  res
);

    localparam int RXW = $clog2(RX_DEPTH);
    localparam int TXW = $clog2(TX_DEPTH);

    esbrac_pkg::phase_t phase_reg, phase_next;
    logic [RXW-1:0]     rx_head_reg, rx_head_next;
    logic [RXW-1:0]     rx_tail_reg, rx_tail_next;
    logic [TXW-1:0]     tx_head_reg, tx_head_next;
    logic [TXW-1:0]     tx_tail_reg, tx_tail_next;
    logic [1:0]         prev_id_reg, prev_id_next;
    logic [15:0]        prev_crc_reg, prev_crc_next;
    logic               last_empty_reg, last_empty_next;
    logic [TXW-1:0]     last_slot_reg, last_slot_next;

    logic [RXW-1:0]     rx_head_inc;
    logic [RXW-1:0]     rx_tail_inc;
    logic [TXW-1:0]     tx_head_inc;
    logic [TXW-1:0]     tx_tail_inc;
    logic [TXW-1:0]     tx_tail_ret;
    logic [TXW-1:0]     tx_head_next_inc;
    logic               again;

    function automatic logic [RXW-1:0] rx_inc(input logic [RXW-1:0] v);
        logic [RXW-1:0] r;
        if (v == RXW'(RX_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = v + RXW'(1);
        end
        return r;
    endfunction

    function automatic logic [TXW-1:0] tx_inc(input logic [TXW-1:0] v);
        logic [TXW-1:0] r;
        if (v == TXW'(TX_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = v + TXW'(1);
        end
        return r;
    endfunction

    function automatic logic [1:0] rx_slot(input logic [RXW-1:0] v);
        logic [RXW+1:0] w;
        w = {2'b00, v};
        return w[1:0];
    endfunction

    function automatic logic [1:0] tx_slot(input logic [TXW-1:0] v);
        logic [TXW+1:0] w;
        w = {2'b00, v};
        return w[1:0];
    endfunction

    assign rx_head_inc = rx_inc(rx_head_reg);
    assign rx_tail_inc = rx_inc(rx_tail_reg);
    assign tx_head_inc = tx_inc(tx_head_reg);
    assign tx_tail_inc = tx_inc(tx_tail_reg);
    assign again       = (req.packet_id == prev_id_reg) && (req.packet_crc == prev_crc_reg);
    assign tx_tail_ret = (!again && !last_empty_reg && (tx_head_reg != tx_tail_reg))
                         ? tx_tail_inc : tx_tail_reg;
    assign tx_head_next_inc = tx_inc(tx_head_next);

    always_comb
    begin
        phase_next      = phase_reg;
        rx_head_next    = rx_head_reg;
        rx_tail_next    = rx_tail_reg;
        tx_head_next    = tx_head_reg;
        tx_tail_next    = tx_tail_reg;
        prev_id_next    = prev_id_reg;
        prev_crc_next   = prev_crc_reg;
        last_empty_next = last_empty_reg;
        last_slot_next  = last_slot_reg;

        res.action      = esbrac_pkg::ACTION_NONE;
        res.buffer_kind = esbrac_pkg::BUF_RX_SLOT;
        res.buffer_slot = 2'b00;
        res.meta_write  = 1'b0;
        res.meta_slot   = 2'b00;

        unique case (req.kind)
            esbrac_pkg::KIND_RADIO_END:
            begin
                unique case (phase_reg)
                    esbrac_pkg::PHASE_RX:
                    begin
                        if (!req.crc_ok)
                        begin
                            res.action      = esbrac_pkg::ACTION_RX_RESTART;
                            res.buffer_slot = rx_slot(rx_head_reg);
                        end
                        else if (rx_head_inc == rx_tail_reg)
                        begin
                            res.action      = esbrac_pkg::ACTION_RX_RESTART;
                            res.buffer_slot = rx_slot(rx_head_reg);
                            res.meta_write  = 1'b1;
                            res.meta_slot   = rx_slot(rx_head_reg);
                        end
                        else
                        begin
                            res.meta_write = 1'b1;
                            res.meta_slot  = rx_slot(rx_head_reg);
                            prev_id_next   = req.packet_id;
                            prev_crc_next  = req.packet_crc;
                            if (!again)
                            begin
                                rx_head_next = rx_head_inc;
                                tx_tail_next = tx_tail_ret;
                                if (tx_tail_ret != tx_head_reg)
                                begin
                                    last_empty_next = 1'b0;
                                    last_slot_next  = tx_tail_ret;
                                end
                                else
                                begin
                                    last_empty_next = 1'b1;
                                    last_slot_next  = '0;
                                end
                            end
                            res.action = esbrac_pkg::ACTION_ACK_TX;
                            if (last_empty_next)
                            begin
                                res.buffer_kind = esbrac_pkg::BUF_EMPTY_ACK;
                            end
                            else
                            begin
                                res.buffer_kind = esbrac_pkg::BUF_TX_SLOT;
                                res.buffer_slot = tx_slot(last_slot_next);
                            end
                            phase_next = esbrac_pkg::PHASE_ACK;
                        end
                    end
                    esbrac_pkg::PHASE_ACK:
                    begin
                        res.action      = esbrac_pkg::ACTION_RX_START;
                        res.buffer_slot = rx_slot(rx_head_reg);
                        phase_next      = esbrac_pkg::PHASE_RX;
                    end
                    default:
                    begin
                        phase_next = esbrac_pkg::PHASE_RX;
                    end
                endcase
            end
            esbrac_pkg::KIND_RX_RELEASE:
            begin
                if (rx_head_reg != rx_tail_reg)
                begin
                    rx_tail_next = rx_tail_inc;
                end
            end
            esbrac_pkg::KIND_TX_COMMIT:
            begin
                if (tx_head_inc != tx_tail_reg)
                begin
                    tx_head_next = tx_head_inc;
                end
            end
            default:
            begin
            end
        endcase

        res.rx_ready      = (rx_head_next != rx_tail_next);
        res.rx_read_slot  = rx_slot(rx_tail_next);
        res.tx_space      = (tx_head_next_inc != tx_tail_next);
        res.tx_write_slot = tx_slot(tx_head_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= esbrac_pkg::PHASE_RX;
            rx_head_reg    <= '0;
            rx_tail_reg    <= '0;
            tx_head_reg    <= '0;
            tx_tail_reg    <= '0;
            prev_id_reg    <= '0;
            prev_crc_reg   <= '0;
            last_empty_reg <= 1'b1;
            last_slot_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            rx_head_reg    <= rx_head_next;
            rx_tail_reg    <= rx_tail_next;
            tx_head_reg    <= tx_head_next;
            tx_tail_reg    <= tx_tail_next;
            prev_id_reg    <= prev_id_next;
            prev_crc_reg   <= prev_crc_next;
            last_empty_reg <= last_empty_next;
            last_slot_reg  <= last_slot_next;
        end
    end

endmodule

@@ sv/esb_receiver_ack_controller_top.sv @@
// Top level of the receiver ack controller: request register, control logic, result register.
//
//   Channel   Direction  Handshake               Payload
//   req       in         req_valid / req_ready   esbrac_pkg::req_t
//   res       out        res_valid / res_ready   esbrac_pkg::res_t
//
// One request per cycle is accepted while results are taken, and one result per request is produced.
// A request is held in the request register until the result register takes the output of
// the combinational control logic behind it, and the result then appears at the output.
// Reset clears the ring indices, the radio phase, the last ack, the previous packet id and CRC and both stage valids.
// A stalled result register holds its result, and the request register fills behind it.
module esb_receiver_ack_controller_top #(
    parameter int RX_DEPTH = esbrac_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = esbrac_pkg::TX_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  esbrac_pkg::req_t req,
    output logic             res_valid,
    input  logic             res_ready,
    output esbrac_pkg::res_t res
);

    logic             s1_valid;
    logic             s2_ready;
    esbrac_pkg::req_t s1_req;
    esbrac_pkg::res_t s1_res;

    esbrac_stage #(
        .data_t (esbrac_pkg::req_t)
    ) u_req_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req_valid),
        .up_ready (req_ready),
        .up_data  (req),
        .dn_valid (s1_valid),
        .dn_ready (s2_ready),
        .dn_data  (s1_req)
    );

    esbrac_ctrl #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_valid && s2_ready),
        .req   (s1_req),
        .res   (s1_res)
    );

    esbrac_stage #(
        .data_t (esbrac_pkg::res_t)
    ) u_res_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s2_ready),
        .up_data  (s1_res),
        .dn_valid (res_valid),
        .dn_ready (res_ready),
        .dn_data  (res)
    );

endmodule

@@ sv/esbrac_checker.sv @@
// Port-level assertion checker for the receiver ack controller, bound to the top level.
`include "esb_receiver_ack_controller_top_macros.svh"

module esbrac_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_ready,
    input esbrac_pkg::res_t res
);

    logic stall;
    logic none_act;
    logic none_ok;
    logic ack_act;
    logic ack_ok;
    logic rearm_act;
    logic rearm_ok;

    assign stall     = res_valid && !res_ready;
    assign none_act  = res_valid && (res.action == esbrac_pkg::ACTION_NONE);
    assign none_ok   = (res.buffer_kind == esbrac_pkg::BUF_RX_SLOT) && (res.buffer_slot == 2'b00)
                       && !res.meta_write && (res.meta_slot == 2'b00);
    assign ack_act   = res_valid && (res.action == esbrac_pkg::ACTION_ACK_TX);
    assign ack_ok    = (res.buffer_kind == esbrac_pkg::BUF_TX_SLOT)
                       || ((res.buffer_kind == esbrac_pkg::BUF_EMPTY_ACK)
                           && (res.buffer_slot == 2'b00));
    assign rearm_act = res_valid && (res.action == esbrac_pkg::ACTION_RX_START);
    assign rearm_ok  = !res.meta_write && (res.buffer_kind == esbrac_pkg::BUF_RX_SLOT);

    // A stalled result must stay valid and unchanged.
    `ESBRAC_ASSERT_NEXT(a_res_hold, stall, res_valid && $stable(res), "stalled result changed")

    // A host request drives no radio buffer and no metadata write.
    `ESBRAC_ASSERT_SAME(a_none_quiet, none_act, none_ok, "idle action with radio fields set")

    // An ack transmit hands out a transmit slot or the empty ack in slot zero.
    `ESBRAC_ASSERT_SAME(a_ack_buffer, ack_act, ack_ok, "bad ack buffer")

    // Rearming receive after a transmit stores no metadata and uses a receive slot.
    `ESBRAC_ASSERT_SAME(a_rearm, rearm_act, rearm_ok, "bad receive rearm")

endmodule

bind esb_receiver_ack_controller_top esbrac_checker u_esbrac_checker (.*);
